@@ sv/nfre_pkg.sv @@
// Shared types and constants for the 4-bpp framebuffer rectangle engine.
// Used by nfre_ctrl, nfre_dpath and nibble_framebuffer_rect_engine; no dependencies.
`default_nettype none

package nfre_pkg;

  // Framebuffer geometry
  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int MIN_WIDTH   = 2;
  localparam int MIN_HEIGHT  = 1;
  localparam int STORE_BYTES = (MAX_WIDTH / 2) * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_BYTES);

  // Pixel store is organized as words of LANES bytes
  localparam int LANES       = 8;
  localparam int LANE_W      = $clog2(LANES);
  localparam int WORD_W      = LANES * 8;
  localparam int STORE_WORDS = STORE_BYTES / LANES;
  localparam int WORD_AW     = ADDR_W - LANE_W;

  // Coordinate widths
  localparam int WW = $clog2(MAX_WIDTH + 1);                          // active width
  localparam int HW = $clog2(MAX_HEIGHT + 1);                         // active height
  localparam int XW = $clog2(MAX_WIDTH);                              // pixel column
  localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;      // pixel row
  localparam int GW = 14;                                             // signed geometry

  // Field widths fixed by the interface
  localparam int DIM_W      = 11;
  localparam int POS_W      = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DARK_MODE    = 2'd2;

  localparam logic [DIM_W-1:0] RST_FRAME_WIDTH  = 11'd960;
  localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT = 11'd540;

  // Command kinds
  localparam logic [2:0] KIND_FILL  = 3'd0;
  localparam logic [2:0] KIND_LINE  = 3'd1;
  localparam logic [2:0] KIND_FRAME = 3'd2;
  localparam logic [2:0] KIND_CLEAR = 3'd3;
  localparam logic [2:0] KIND_READ  = 3'd4;

  // Outline frame segments
  localparam logic [1:0] SEG_TOP    = 2'd0;
  localparam logic [1:0] SEG_BOTTOM = 2'd1;
  localparam logic [1:0] SEG_LEFT   = 2'd2;
  localparam logic [1:0] SEG_RIGHT  = 2'd3;

  // Byte constants
  localparam logic [7:0] NIB_LO_MASK = 8'h0F;
  localparam logic [7:0] NIB_HI_MASK = 8'hF0;
  localparam logic [7:0] PAPER_LIGHT = 8'hFF;
  localparam logic [7:0] PAPER_DARK  = 8'h00;

  typedef struct packed {
    logic [2:0]              kind;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [DIM_W-1:0]        extent_w;
    logic [DIM_W-1:0]        extent_h;
    logic [7:0]              shade;
  } req_t;

  typedef struct packed {
    logic [3:0] pixel_level;
    logic       in_bounds;
  } rsp_t;

  typedef struct packed {
    logic [DIM_W-1:0] frame_width;
    logic [DIM_W-1:0] frame_height;
    logic             dark_mode;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SEG_SETUP,
    ST_SEG_CHECK,
    ST_PX_ADDR,
    ST_PX_READ,
    ST_PX_WRITE,
    ST_RD_ADDR,
    ST_RD_MEM,
    ST_RD_TAKE,
    ST_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic       load;       // capture request, zero result
    logic       seg_setup;  // compute clipped bounds of segment seg
    logic [1:0] seg;
    logic       px_addr;    // form byte address of walk pixel
    logic       rd_addr;    // form byte address of read pixel, check bounds
    logic       mem_rd;     // read the addressed word
    logic       px_write;   // merge nibble, write back, advance walk
    logic       rd_take;    // capture read result
    logic       clr_start;  // latch paper byte, rewind sweep
    logic       clr_step;   // write one word of paper
    logic       finish;     // present result
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic seg_empty;
    logic px_last;
    logic clr_last;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ sv/nfre_ctrl.sv @@
// Command sequencer of the framebuffer rectangle engine.
// Depends on nfre_pkg; drives nfre_dpath through dp_cmd_t, reads dp_stat_t.
`default_nettype none

module nfre_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [2:0]        kind,
  input  wire logic              cfg_resize,
  input  wire nfre_pkg::dp_stat_t stat,
  output nfre_pkg::dp_cmd_t      cmd,
  output logic                   busy
);

  nfre_pkg::state_t state_r, state_nxt;
  logic [1:0]       seg_r, seg_nxt;
  logic             frame_r, frame_nxt;
  logic             report_r, report_nxt;
  logic             last_seg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= nfre_pkg::ST_IDLE;
      seg_r    <= nfre_pkg::SEG_TOP;
      frame_r  <= 1'b0;
      report_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      seg_r    <= seg_nxt;
      frame_r  <= frame_nxt;
      report_r <= report_nxt;
    end
  end

  assign last_seg = !frame_r || (seg_r == nfre_pkg::SEG_RIGHT);
  assign busy     = (state_r != nfre_pkg::ST_IDLE);

  always_comb begin
    state_nxt  = state_r;
    seg_nxt    = seg_r;
    frame_nxt  = frame_r;
    report_nxt = report_r;
    cmd        = '0;
    cmd.seg    = seg_r;
    unique case (state_r)
      nfre_pkg::ST_IDLE: begin
        if (cfg_resize) begin
          cmd.clr_start = 1'b1;
          report_nxt    = 1'b0;
          state_nxt     = nfre_pkg::ST_CLEAR;
        end else if (start) begin
          cmd.load  = 1'b1;
          seg_nxt   = nfre_pkg::SEG_TOP;
          frame_nxt = (kind == nfre_pkg::KIND_FRAME);
          unique case (kind) inside
            nfre_pkg::KIND_FILL, nfre_pkg::KIND_LINE, nfre_pkg::KIND_FRAME: begin
              state_nxt = nfre_pkg::ST_SEG_SETUP;
            end
            nfre_pkg::KIND_CLEAR: begin
              cmd.clr_start = 1'b1;
              report_nxt    = 1'b1;
              state_nxt     = nfre_pkg::ST_CLEAR;
            end
            nfre_pkg::KIND_READ: begin
              state_nxt = nfre_pkg::ST_RD_ADDR;
            end
            default: begin
              state_nxt = nfre_pkg::ST_DONE;
            end
          endcase
        end
      end
      nfre_pkg::ST_CLEAR: begin
        if (cfg_resize) begin
          cmd.clr_start = 1'b1;
        end else begin
          cmd.clr_step = 1'b1;
          if (stat.clr_last) begin
            state_nxt = report_r ? nfre_pkg::ST_DONE : nfre_pkg::ST_IDLE;
          end
        end
      end
      nfre_pkg::ST_SEG_SETUP: begin
        cmd.seg_setup = 1'b1;
        state_nxt     = nfre_pkg::ST_SEG_CHECK;
      end
      nfre_pkg::ST_SEG_CHECK: begin
        if (!stat.seg_empty) begin
          state_nxt = nfre_pkg::ST_PX_ADDR;
        end else if (last_seg) begin
          state_nxt = nfre_pkg::ST_DONE;
        end else begin
          seg_nxt   = seg_r + 2'd1;
          state_nxt = nfre_pkg::ST_SEG_SETUP;
        end
      end
      nfre_pkg::ST_PX_ADDR: begin
        cmd.px_addr = 1'b1;
        state_nxt   = nfre_pkg::ST_PX_READ;
      end
      nfre_pkg::ST_PX_READ: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = nfre_pkg::ST_PX_WRITE;
      end
      nfre_pkg::ST_PX_WRITE: begin
        cmd.px_write = 1'b1;
        if (!stat.px_last) begin
          state_nxt = nfre_pkg::ST_PX_ADDR;
        end else if (last_seg) begin
          state_nxt = nfre_pkg::ST_DONE;
        end else begin
          seg_nxt   = seg_r + 2'd1;
          state_nxt = nfre_pkg::ST_SEG_SETUP;
        end
      end
      nfre_pkg::ST_RD_ADDR: begin
        cmd.rd_addr = 1'b1;
        state_nxt   = nfre_pkg::ST_RD_MEM;
      end
      nfre_pkg::ST_RD_MEM: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = nfre_pkg::ST_RD_TAKE;
      end
      nfre_pkg::ST_RD_TAKE: begin
        cmd.rd_take = 1'b1;
        state_nxt   = nfre_pkg::ST_DONE;
      end
      nfre_pkg::ST_DONE: begin
        cmd.finish = 1'b1;
        state_nxt  = nfre_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = nfre_pkg::ST_IDLE;
      end
    endcase
  end

  // Each pixel is one read followed by one write of the same word
  a_rmw_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == nfre_pkg::ST_PX_WRITE |-> $past(state_r) == nfre_pkg::ST_PX_READ)
    else $error("pixel write without preceding read");

  // Segment index only moves forward within an outline frame
  a_seg_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && seg_r != nfre_pkg::SEG_TOP) |-> frame_r)
    else $error("segment index advanced outside a frame command");

  // Read path runs address, memory, capture in order
  a_rd_seq: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == nfre_pkg::ST_RD_ADDR |=> state_r == nfre_pkg::ST_RD_MEM)
    else $error("read sequence broken");

endmodule

`default_nettype wire

@@ sv/nfre_dpath.sv @@
// Datapath of the framebuffer rectangle engine: clipping, pixel walk,
// nibble read-modify-write, clear sweep and the pixel store. Depends on nfre_pkg.
`default_nettype none

module nfre_dpath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire nfre_pkg::dp_cmd_t cmd,
  input  wire nfre_pkg::req_t    in_req,
  input  wire nfre_pkg::cfg_t    cfg,
  output nfre_pkg::dp_stat_t     stat,
  output logic                   out_valid,
  output nfre_pkg::rsp_t         out_rsp
);

  localparam int GW = nfre_pkg::GW;
  localparam int XW = nfre_pkg::XW;
  localparam int YW = nfre_pkg::YW;
  localparam int WW = nfre_pkg::WW;
  localparam int HW = nfre_pkg::HW;
  localparam int AW = nfre_pkg::ADDR_W;
  localparam int LW = nfre_pkg::LANE_W;
  localparam int PW = YW + WW - 1;

  logic [nfre_pkg::WORD_W-1:0] mem [nfre_pkg::STORE_WORDS];

  nfre_pkg::req_t              req_r;
  nfre_pkg::rsp_t              res_r;
  nfre_pkg::rsp_t              out_rsp_r;
  logic                        out_valid_r;
  logic [7:0]                  paper_r;
  logic [nfre_pkg::WORD_AW-1:0] clr_cnt_r;
  logic                        seg_empty_r;
  logic [XW-1:0]               xlo_r, xlast_r, cx_r;
  logic [YW-1:0]               ylast_r, cy_r;
  logic [AW-1:0]               addr_r;
  logic                        nib_hi_r;
  logic                        rd_ok_r;
  logic [nfre_pkg::WORD_W-1:0] rd_word_r;

  // Active size after clamping
  logic [WW-1:0]        act_w;
  logic [HW-1:0]        act_h;
  logic [WW-2:0]        stride;
  logic signed [GW-1:0] aw_s, ah_s;

  always_comb begin
    if (int'(cfg.frame_width) < nfre_pkg::MIN_WIDTH) begin
      act_w = WW'(nfre_pkg::MIN_WIDTH);
    end else if (int'(cfg.frame_width) > nfre_pkg::MAX_WIDTH) begin
      act_w = WW'(nfre_pkg::MAX_WIDTH);
    end else begin
      act_w = WW'(cfg.frame_width);
    end
    if (int'(cfg.frame_height) < nfre_pkg::MIN_HEIGHT) begin
      act_h = HW'(nfre_pkg::MIN_HEIGHT);
    end else if (int'(cfg.frame_height) > nfre_pkg::MAX_HEIGHT) begin
      act_h = HW'(nfre_pkg::MAX_HEIGHT);
    end else begin
      act_h = HW'(cfg.frame_height);
    end
  end

  assign stride = act_w[WW-1:1];
  assign aw_s   = $signed(GW'(act_w));
  assign ah_s   = $signed(GW'(act_h));

  // Segment geometry and clipping
  logic signed [GW-1:0] px, py, ew, eh;
  logic signed [GW-1:0] sx, sy, sw, sh;
  logic signed [GW-1:0] xlo_s, ylo_s, xend_s, yend_s, xhi_s, yhi_s, xlast_s, ylast_s;
  logic                 seg_empty;

  assign px = GW'(req_r.pos_x);
  assign py = GW'(req_r.pos_y);
  assign ew = $signed(GW'(req_r.extent_w));
  assign eh = $signed(GW'(req_r.extent_h));

  always_comb begin
    sx = px;
    sy = py;
    sw = ew;
    sh = eh;
    if (req_r.kind == nfre_pkg::KIND_LINE) begin
      sh = GW'(1);
    end else if (req_r.kind == nfre_pkg::KIND_FRAME) begin
      case (cmd.seg)
        nfre_pkg::SEG_TOP: begin
          sh = GW'(1);
        end
        nfre_pkg::SEG_BOTTOM: begin
          sy = py + eh - GW'(1);
          sh = GW'(1);
        end
        nfre_pkg::SEG_LEFT: begin
          sw = GW'(1);
        end
        default: begin
          sx = px + ew - GW'(1);
          sw = GW'(1);
        end
      endcase
    end
    xlo_s     = (sx < 0) ? '0 : sx;
    ylo_s     = (sy < 0) ? '0 : sy;
    xend_s    = sx + sw;
    yend_s    = sy + sh;
    xhi_s     = (xend_s > aw_s) ? aw_s : xend_s;
    yhi_s     = (yend_s > ah_s) ? ah_s : yend_s;
    xlast_s   = xhi_s - GW'(1);
    ylast_s   = yhi_s - GW'(1);
    seg_empty = (xlo_s >= xhi_s) || (ylo_s >= yhi_s);
  end

  // Byte address of a pixel
  logic [XW-1:0] src_x;
  logic [YW-1:0] src_y;
  logic [PW-1:0] row_base;
  logic [AW-1:0] addr_nxt;
  logic          rd_ok;

  assign src_x    = cmd.rd_addr ? req_r.pos_x[XW-1:0] : cx_r;
  assign src_y    = cmd.rd_addr ? req_r.pos_y[YW-1:0] : cy_r;
  assign row_base = src_y * stride;
  assign addr_nxt = AW'(row_base) + AW'(src_x[XW-1:1]);
  assign rd_ok    = (px >= 0) && (px < aw_s) && (py >= 0) && (py < ah_s);

  // Byte lane selection and nibble merge
  logic [LW+2:0]                 bit_lo;
  logic [7:0]                    rd_byte, wr_byte;
  logic [nfre_pkg::WORD_AW-1:0]  word_idx;

  assign word_idx = addr_r[AW-1:LW];
  assign bit_lo   = {addr_r[LW-1:0], 3'b000};
  assign rd_byte  = rd_word_r[bit_lo +: 8];
  assign wr_byte  = nib_hi_r
                  ? ((rd_byte & nfre_pkg::NIB_LO_MASK) | (req_r.shade & nfre_pkg::NIB_HI_MASK))
                  : ((rd_byte & nfre_pkg::NIB_HI_MASK) | {4'h0, req_r.shade[7:4]});

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      mem[clr_cnt_r] <= {nfre_pkg::LANES{paper_r}};
    end else if (cmd.px_write) begin
      mem[word_idx][bit_lo +: 8] <= wr_byte;
    end
    if (cmd.mem_rd) begin
      rd_word_r <= mem[word_idx];
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_req;
      res_r <= '0;
    end
    if (cmd.clr_start) begin
      paper_r <= cfg.dark_mode ? nfre_pkg::PAPER_DARK : nfre_pkg::PAPER_LIGHT;
    end
    if (cmd.seg_setup) begin
      seg_empty_r <= seg_empty;
      xlo_r       <= xlo_s[XW-1:0];
      xlast_r     <= xlast_s[XW-1:0];
      ylast_r     <= ylast_s[YW-1:0];
      cx_r        <= xlo_s[XW-1:0];
      cy_r        <= ylo_s[YW-1:0];
    end else if (cmd.px_write) begin
      if (cx_r == xlast_r) begin
        cx_r <= xlo_r;
        cy_r <= cy_r + YW'(1);
      end else begin
        cx_r <= cx_r + XW'(1);
      end
    end
    if (cmd.px_addr || cmd.rd_addr) begin
      addr_r   <= addr_nxt;
      nib_hi_r <= src_x[0];
    end
    if (cmd.rd_addr) begin
      rd_ok_r <= rd_ok;
    end
    if (cmd.rd_take) begin
      res_r.in_bounds   <= rd_ok_r;
      res_r.pixel_level <= !rd_ok_r ? 4'h0 : (nib_hi_r ? rd_byte[7:4] : rd_byte[3:0]);
    end
    if (cmd.finish) begin
      out_rsp_r <= res_r;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      clr_cnt_r   <= '0;
    end else begin
      out_valid_r <= cmd.finish;
      if (cmd.clr_start) begin
        clr_cnt_r <= '0;
      end else if (cmd.clr_step) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
    end
  end

  assign stat.seg_empty = seg_empty_r;
  assign stat.px_last   = (cx_r == xlast_r) && (cy_r == ylast_r);
  assign stat.clr_last  = &clr_cnt_r;
  assign out_valid      = out_valid_r;
  assign out_rsp        = out_rsp_r;

  // A rewound sweep starts from word zero
  a_clr_rewind: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_start |=> clr_cnt_r == '0)
    else $error("clear sweep not rewound");

  // The walk never leaves the clipped row range
  a_walk_rows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.px_addr && !seg_empty_r) |-> cy_r <= ylast_r)
    else $error("pixel walk past last row");

  // A result is shown only for one cycle after a finish
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(cmd.finish))
    else $error("result strobe without finish");

endmodule

`default_nettype wire

@@ sv/nibble_framebuffer_rect_engine.sv @@
// Rectangle engine over a 4-bpp framebuffer: 64K x 8-byte pixel store, fill, line,
// frame, clear, read. A read addresses, reads and captures; unused kinds go straight to
// the result. A draw sets up and checks each segment (one for fill and line, four for a
// frame), then a single-port nibble read-modify-write per covered pixel; a clear writes
// one 8-byte word per cycle, restarted by a size write. busy drops as the result shows,
// one request at a time; a size write holds busy. The receiver cannot stall out_valid.
// Reset (rst_n, sync) restores 960 x 540, light paper; store undefined until cleared.
`default_nettype none

module nibble_framebuffer_rect_engine (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // Request channel
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire nfre_pkg::req_t                       in_req,
  // Result channel: one-cycle strobe, no back-pressure
  output logic                                      out_valid,
  output nfre_pkg::rsp_t                            out_rsp,
  // Register write port
  input  wire logic                                 cfg_we,
  input  wire logic [nfre_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  wire logic [nfre_pkg::CFG_DATA_W-1:0]      cfg_data
);

  nfre_pkg::cfg_t     cfg_r;
  nfre_pkg::dp_cmd_t  cmd;
  nfre_pkg::dp_stat_t stat;
  logic               cfg_resize;

  // Register file. A resize while the sequencer is idle or clearing also wipes the store
  // to the current paper byte, so flag writes to either size register for the sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width  <= nfre_pkg::RST_FRAME_WIDTH;
      cfg_r.frame_height <= nfre_pkg::RST_FRAME_HEIGHT;
      cfg_r.dark_mode    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        nfre_pkg::REG_FRAME_WIDTH:  cfg_r.frame_width  <= cfg_data;
        nfre_pkg::REG_FRAME_HEIGHT: cfg_r.frame_height <= cfg_data;
        nfre_pkg::REG_DARK_MODE:    cfg_r.dark_mode    <= cfg_data[0];
        default: begin
          // unmapped index: drop the write
        end
      endcase
    end
  end

  assign cfg_resize = cfg_we && ((cfg_idx == nfre_pkg::REG_FRAME_WIDTH) ||
                                 (cfg_idx == nfre_pkg::REG_FRAME_HEIGHT));

  // Sequencer: decodes the request kind, walks segments and pixels, runs clears
  nfre_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .kind       (in_req.kind),
    .cfg_resize (cfg_resize),
    .stat       (stat),
    .cmd        (cmd),
    .busy       (busy)
  );

  // Datapath: clipping, addressing, nibble merge, pixel store, result register
  nfre_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_req    (in_req),
    .cfg       (cfg_r),
    .stat      (stat),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

  // One result per request, never back to back
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // An accepted request keeps the engine busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted but engine not busy");

  // The result leaves as the engine goes idle
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while engine busy");

endmodule

`default_nettype wire

@@ dv/nfre_pixel_checker.sv @@
`timescale 1ns / 1ps
// Checker for the 4-bpp framebuffer rectangle engine: mirrors the pixel store,
// predicts each readout and compares it with the result strobe. Depends on nfre_pkg.
module nfre_pixel_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic                            busy,
  input  nfre_pkg::req_t                  in_req,
  input  logic                            out_valid,
  input  nfre_pkg::rsp_t                  out_rsp,
  input  logic                            cfg_we,
  input  logic [nfre_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [nfre_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              readouts_due
);

  localparam int REPORT_LIMIT = 10;
  localparam int POS_W        = nfre_pkg::POS_W;

  logic [nfre_pkg::DIM_W-1:0] width_reg;
  logic [nfre_pkg::DIM_W-1:0] height_reg;
  logic                       dark_reg;
  logic [7:0]                 paper_byte;
  // Bytes written since the last wipe; any other byte holds the paper byte.
  logic [7:0]                 shadow_store [int];
  nfre_pkg::rsp_t             expected_readouts [$];
  nfre_pkg::rsp_t             want;

  initial begin
    fail_count   = 0;
    readouts_due = 0;
  end

  function automatic int active_width();
    if (width_reg < nfre_pkg::MIN_WIDTH) return nfre_pkg::MIN_WIDTH;
    if (width_reg > nfre_pkg::MAX_WIDTH) return nfre_pkg::MAX_WIDTH;
    return int'(width_reg);
  endfunction

  function automatic int active_height();
    if (height_reg < nfre_pkg::MIN_HEIGHT) return nfre_pkg::MIN_HEIGHT;
    if (height_reg > nfre_pkg::MAX_HEIGHT) return nfre_pkg::MAX_HEIGHT;
    return int'(height_reg);
  endfunction

  function automatic int byte_index(int x, int y);
    return (y * (active_width() / 2) + x / 2) % nfre_pkg::STORE_BYTES;
  endfunction

  function automatic logic [7:0] peek_byte(int a);
    return shadow_store.exists(a) ? shadow_store[a] : paper_byte;
  endfunction

  function automatic void wipe_store();
    shadow_store.delete();
    paper_byte = dark_reg ? nfre_pkg::PAPER_DARK : nfre_pkg::PAPER_LIGHT;
  endfunction

  function automatic void paint(int x, int y, logic [7:0] shade);
    int         a;
    logic [7:0] b;
    if (x < 0 || x >= active_width() || y < 0 || y >= active_height()) return;
    a = byte_index(x, y);
    b = peek_byte(a);
    if (x[0]) b = (b & nfre_pkg::NIB_LO_MASK) | (shade & nfre_pkg::NIB_HI_MASK);
    else      b = (b & nfre_pkg::NIB_HI_MASK) | {4'h0, shade[7:4]};
    shadow_store[a] = b;
  endfunction

  function automatic void paint_row(int x, int y, int w, logic [7:0] shade);
    int lo;
    int hi;
    if (y < 0 || y >= active_height()) return;
    lo = (x < 0) ? 0 : x;
    hi = x + w;
    if (hi > active_width()) hi = active_width();
    for (int i = lo; i < hi; i++) paint(i, y, shade);
  endfunction

  function automatic void paint_column(int x, int y, int h, logic [7:0] shade);
    int lo;
    int hi;
    if (x < 0 || x >= active_width()) return;
    lo = (y < 0) ? 0 : y;
    hi = y + h;
    if (hi > active_height()) hi = active_height();
    for (int j = lo; j < hi; j++) paint(x, j, shade);
  endfunction

  // Apply one command to the shadow store and return the readout it produces.
  function automatic nfre_pkg::rsp_t predict_readout(nfre_pkg::req_t r);
    nfre_pkg::rsp_t o;
    int             x;
    int             y;
    int             w;
    int             h;
    int             row_lo;
    int             row_hi;
    logic [7:0]     b;
    o = '0;
    x = {{(32-POS_W){r.pos_x[POS_W-1]}}, r.pos_x};
    y = {{(32-POS_W){r.pos_y[POS_W-1]}}, r.pos_y};
    w = int'(r.extent_w);
    h = int'(r.extent_h);
    case (r.kind)
      nfre_pkg::KIND_FILL: begin
        row_lo = (y < 0) ? 0 : y;
        row_hi = y + h;
        if (row_hi > active_height()) row_hi = active_height();
        for (int j = row_lo; j < row_hi; j++) paint_row(x, j, w, r.shade);
      end
      nfre_pkg::KIND_LINE: paint_row(x, y, w, r.shade);
      nfre_pkg::KIND_FRAME: begin
        paint_row(x, y, w, r.shade);
        paint_row(x, y + h - 1, w, r.shade);
        paint_column(x, y, h, r.shade);
        paint_column(x + w - 1, y, h, r.shade);
      end
      nfre_pkg::KIND_CLEAR: wipe_store();
      nfre_pkg::KIND_READ: begin
        if (x >= 0 && x < active_width() && y >= 0 && y < active_height()) begin
          b = peek_byte(byte_index(x, y));
          o.pixel_level = x[0] ? b[7:4] : b[3:0];
          o.in_bounds   = 1'b1;
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  task automatic log_failure(input string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg  = nfre_pkg::RST_FRAME_WIDTH;
      height_reg = nfre_pkg::RST_FRAME_HEIGHT;
      dark_reg   = 1'b0;
      paper_byte = nfre_pkg::PAPER_LIGHT;
      shadow_store.delete();
      expected_readouts.delete();
    end else begin
      if (out_valid) begin
        if (expected_readouts.size() == 0) begin
          log_failure($sformatf("result with no request pending: level %0h in_bounds %0b",
                                out_rsp.pixel_level, out_rsp.in_bounds));
        end else begin
          want = expected_readouts.pop_front();
          if (out_rsp.pixel_level !== want.pixel_level ||
              out_rsp.in_bounds !== want.in_bounds)
            log_failure($sformatf({"readout mismatch: level exp %0h got %0h, ",
                                   "in_bounds exp %0b got %0b"},
                                  want.pixel_level, out_rsp.pixel_level,
                                  want.in_bounds, out_rsp.in_bounds));
        end
      end
      if (start && !busy) expected_readouts.push_back(predict_readout(in_req));
      if (cfg_we) begin
        case (cfg_idx)
          nfre_pkg::REG_FRAME_WIDTH: begin
            width_reg = cfg_data;
            wipe_store();
          end
          nfre_pkg::REG_FRAME_HEIGHT: begin
            height_reg = cfg_data;
            wipe_store();
          end
          nfre_pkg::REG_DARK_MODE: dark_reg = cfg_data[0];
          default: ;
        endcase
      end
    end
    readouts_due = expected_readouts.size();
  end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench top for nibble_framebuffer_rect_engine: reset, register settings and
// command stimulus, verdict. Depends on nfre_pkg and nfre_pixel_checker.
module tb_top;

  localparam int POS_W      = nfre_pkg::POS_W;
  localparam int DIM_W      = nfre_pkg::DIM_W;
  localparam int CFG_IDX_W  = nfre_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = nfre_pkg::CFG_DATA_W;

  // Allow a silence well beyond a full wipe of the store.
  localparam int QUIET_LIMIT  = 400_000;
  // Cycles to linger after the last result.
  localparam int DRAIN_CYCLES = 64;

  logic                  clk      = 1'b0;
  logic                  rst_n    = 1'b0;
  logic                  start    = 1'b0;
  nfre_pkg::req_t        in_req   = '0;
  logic                  cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  busy;
  logic                  out_valid;
  nfre_pkg::rsp_t        out_rsp;
  int                    fail_count;
  int                    readouts_due;

  // Stimulus shaping: the active area as the block sees it, the chance of a sender
  // pause per request, and where the last drawing landed so reads can look there.
  int frame_w_now = 960;
  int frame_h_now = 540;
  int idle_pct    = 0;
  int last_x      = 0;
  int last_y      = 0;
  int quiet_cycles = 0;

  always #1 clk = ~clk;

  nibble_framebuffer_rect_engine DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_rsp   (out_rsp),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data)
  );

  nfre_pixel_checker pixel_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_req       (in_req),
    .out_valid    (out_valid),
    .out_rsp      (out_rsp),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .readouts_due (readouts_due)
  );

  // Watchdog: restart on any accepted request, result or register write.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one request and hold it until the block takes it. Optionally drop start
  // for a random burst first, sometimes only once the block has gone idle so the
  // pause lands between commands rather than inside one.
  task automatic issue_request(input nfre_pkg::req_t r);
    int gap;
    gap = 0;
    if (int'($urandom_range(0, 99)) < idle_pct) gap = $urandom_range(1, 10);
    if (gap != 0) begin
      start <= 1'b0;
      if ($urandom_range(0, 1) == 0) begin
        @(posedge clk);
        while (busy) @(posedge clk);
      end
      repeat (gap) @(posedge clk);
    end
    start  <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (r.kind == nfre_pkg::KIND_FILL || r.kind == nfre_pkg::KIND_LINE ||
        r.kind == nfre_pkg::KIND_FRAME) begin
      last_x = {{(32-POS_W){r.pos_x[POS_W-1]}}, r.pos_x};
      last_y = {{(32-POS_W){r.pos_y[POS_W-1]}}, r.pos_y};
    end
  endtask

  task automatic issue_cmd(input logic [2:0] kind, input int x, input int y,
                           input int w, input int h, input logic [7:0] shade);
    nfre_pkg::req_t r;
    r.kind     = kind;
    r.pos_x    = POS_W'(x);
    r.pos_y    = POS_W'(y);
    r.extent_w = DIM_W'(w);
    r.extent_h = DIM_W'(h);
    r.shade    = shade;
    issue_request(r);
  endtask

  // Drop start and hold off until every readout is back and the block is idle.
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (readouts_due != 0);
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Write one register while idle. Size writes start a wipe of the store, so
  // step past the rise of busy and then wait for it to fall.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == nfre_pkg::REG_FRAME_WIDTH)
      frame_w_now = (value < nfre_pkg::MIN_WIDTH) ? nfre_pkg::MIN_WIDTH :
                    (value > nfre_pkg::MAX_WIDTH) ? nfre_pkg::MAX_WIDTH : value;
    if (idx == nfre_pkg::REG_FRAME_HEIGHT)
      frame_h_now = (value < nfre_pkg::MIN_HEIGHT) ? nfre_pkg::MIN_HEIGHT :
                    (value > nfre_pkg::MAX_HEIGHT) ? nfre_pkg::MAX_HEIGHT : value;
    repeat (3) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Coordinate: mostly around the active area, edges included, sometimes anywhere.
  function automatic int pick_coord(input int lim);
    if ($urandom_range(0, 3) == 0) return int'($urandom_range(0, 4095)) - 2048;
    return int'($urandom_range(0, lim + 3)) - 2;
  endfunction

  // Extent: half the time the full field range, else near the active size.
  function automatic int pick_extent(input int lim);
    if ($urandom_range(0, 1) == 0) return $urandom_range(0, 2047);
    return $urandom_range(0, lim + 2);
  endfunction

  // Random commands against the current setting. On large areas keep fills and
  // most strokes short so the pixel walk stays cheap; clipping still gets hit
  // through coordinates that run off the edges.
  task automatic random_burst(input int count);
    nfre_pkg::req_t r;
    int             roll;
    bit             roomy;
    roomy = (frame_w_now * frame_h_now > 2048);
    for (int n = 0; n < count; n++) begin
      roll       = $urandom_range(0, 255);
      r.shade    = 8'($urandom_range(0, 255));
      r.pos_x    = POS_W'(pick_coord(frame_w_now));
      r.pos_y    = POS_W'(pick_coord(frame_h_now));
      r.extent_w = DIM_W'(pick_extent(frame_w_now));
      r.extent_h = DIM_W'(pick_extent(frame_h_now));
      if (roll < 2)        r.kind = nfre_pkg::KIND_CLEAR;
      else if (roll < 10)  r.kind = nfre_pkg::KIND_READ + 3'($urandom_range(1, 3));
      else if (roll < 100) r.kind = nfre_pkg::KIND_READ;
      else if (roll < 160) r.kind = nfre_pkg::KIND_FILL;
      else if (roll < 200) r.kind = nfre_pkg::KIND_LINE;
      else                 r.kind = nfre_pkg::KIND_FRAME;
      // Aim half the reads at the last stroke so drawn pixels get read back.
      if (r.kind == nfre_pkg::KIND_READ && $urandom_range(0, 1) == 0) begin
        r.pos_x = POS_W'(last_x + int'($urandom_range(0, 6)) - 3);
        r.pos_y = POS_W'(last_y + int'($urandom_range(0, 6)) - 3);
      end
      if (roomy && r.kind == nfre_pkg::KIND_FILL) begin
        if ($urandom_range(0, 7) == 0) begin
          r.extent_w = DIM_W'($urandom_range(0, 2047));
          r.extent_h = DIM_W'($urandom_range(0, 2));
        end else begin
          r.extent_w = DIM_W'($urandom_range(0, 40));
          r.extent_h = DIM_W'($urandom_range(0, 12));
        end
      end else if (roomy && $urandom_range(0, 3) != 0) begin
        r.extent_w = DIM_W'($urandom_range(0, 40));
        r.extent_h = DIM_W'($urandom_range(0, 40));
      end
      issue_request(r);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset setting, 960 x 540 on light paper. Wipe first: the store holds
    // garbage until then, and nothing may read it before.
    idle_pct = 25;
    issue_cmd(nfre_pkg::KIND_CLEAR, 0, 0, 0, 0, 8'h00);
    random_burst(40);
    drain();

    // Tiny odd-width area on dark paper: the last column aliases into the
    // next row's first byte.
    write_reg(nfre_pkg::REG_DARK_MODE, 1);
    write_reg(nfre_pkg::REG_FRAME_WIDTH, 7);
    write_reg(nfre_pkg::REG_FRAME_HEIGHT, 5);
    issue_cmd(nfre_pkg::KIND_READ, 0, 0, 0, 0, 8'h00);        // dark paper after resize
    issue_cmd(nfre_pkg::KIND_FILL, 0, 0, 2047, 2047, 8'hFF);  // whole area, max extents
    issue_cmd(nfre_pkg::KIND_READ, 6, 0, 0, 0, 8'h00);        // last column of an odd width
    issue_cmd(nfre_pkg::KIND_READ, 0, 1, 0, 0, 8'h00);
    issue_cmd(nfre_pkg::KIND_LINE, -2048, 2, 2047, 0, 8'h00); // ends just left of the area
    issue_cmd(nfre_pkg::KIND_LINE, -5, 1, 8, 0, 8'h3C);       // clipped on the left
    issue_cmd(nfre_pkg::KIND_FILL, 2047, 2047, 2047, 2047, 8'h0F);
    issue_cmd(nfre_pkg::KIND_FRAME, 2, 1, 0, 3, 8'h70);       // zero width: columns x, x-1
    issue_cmd(nfre_pkg::KIND_FRAME, 1, 3, 4, 0, 8'h5A);       // zero height: rows y, y-1
    issue_cmd(nfre_pkg::KIND_FRAME, -1, -1, 9, 7, 8'hC0);     // border clipped on all sides
    issue_cmd(nfre_pkg::KIND_LINE, 6, 4, 1, 0, 8'h90);        // alias past the last row
    issue_cmd(nfre_pkg::KIND_READ, 6, 4, 0, 0, 8'h00);
    issue_cmd(nfre_pkg::KIND_READ, 0, 5, 0, 0, 8'h00);        // one row below the area
    issue_cmd(nfre_pkg::KIND_READ, -1, 0, 0, 0, 8'h00);
    issue_cmd(nfre_pkg::KIND_READ, 7, 0, 0, 0, 8'h00);
    issue_cmd(nfre_pkg::KIND_READ, 2047, 2047, 0, 0, 8'h00);
    issue_cmd(nfre_pkg::KIND_READ, -2048, -2048, 0, 0, 8'h00);
    issue_cmd(nfre_pkg::KIND_READ, 1, 1, 0, 0, 8'h00);
    issue_cmd(nfre_pkg::KIND_READ, 2, 2, 0, 0, 8'h00);
    issue_cmd(nfre_pkg::KIND_READ, 3, 3, 0, 0, 8'h00);
    // Unused kinds do nothing.
    issue_cmd(nfre_pkg::KIND_READ + 3'd1, -1, -1, 2047, 2047, 8'hFF);
    issue_cmd(nfre_pkg::KIND_READ + 3'd3, 0, 0, 0, 0, 8'h00);
    issue_cmd(nfre_pkg::KIND_CLEAR, 0, 0, 0, 0, 8'hFF);
    issue_cmd(nfre_pkg::KIND_READ, 4, 2, 0, 0, 8'h00);
    random_burst(60);
    // Pause the sender until every readout is back before touching registers.
    drain();

    // Sizes below the legal range clamp to 2 x 1; back-to-back requests.
    idle_pct = 0;
    write_reg(nfre_pkg::REG_DARK_MODE, 0);
    write_reg(nfre_pkg::REG_FRAME_WIDTH, 1);
    write_reg(nfre_pkg::REG_FRAME_HEIGHT, 0);
    random_burst(40);
    drain();

    // Sizes above the range clamp to the full 1024 x 1024 store.
    idle_pct = 40;
    write_reg(nfre_pkg::REG_DARK_MODE, 1);
    write_reg(nfre_pkg::REG_FRAME_WIDTH, 2047);
    write_reg(nfre_pkg::REG_FRAME_HEIGHT, 2047);
    random_burst(40);
    drain();

    // Full width, single row.
    write_reg(nfre_pkg::REG_FRAME_HEIGHT, 1);
    random_burst(50);
    drain();

    // Mid-size area on light paper with heavy random traffic.
    idle_pct = 25;
    write_reg(nfre_pkg::REG_DARK_MODE, 0);
    write_reg(nfre_pkg::REG_FRAME_WIDTH, 64);
    write_reg(nfre_pkg::REG_FRAME_HEIGHT, 16);
    random_burst(100);
    drain();

    // Same area, dark paper for later wipes; no sender pauses to the end.
    idle_pct = 0;
    write_reg(nfre_pkg::REG_DARK_MODE, 1);
    random_burst(100);
    drain();

    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0 && readouts_due == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
